FILE: src/urb_pkg.sv
package urb_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    REQ_CPU_WRITE  = 3'd0,
    REQ_CPU_READ   = 3'd1,
    REQ_LINE_RX    = 3'd2,
    REQ_LINE_TX    = 3'd3,
    REQ_CLR_RX_OVR = 3'd4,
    REQ_CLR_TX_OVR = 3'd5,
    REQ_FLUSH_RX   = 3'd6,
    REQ_FLUSH_TX   = 3'd7
  } req_type_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;   // capture the request beat
    logic insert;  // push the line-end byte ahead of a cpu write, if one is due
    logic exec;    // carry out the request
    logic load;    // fill the result register
  } urb_cmd_t;

  typedef struct packed {
    logic out_full;  // result register still holds an untaken beat
  } urb_sts_t;

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t n;
    n = (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    return n;
  endfunction

endpackage

FILE: src/urb_req_if.sv
interface urb_req_if;
  import urb_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic       line_error;

  modport source (output valid, output req_type, output data_byte, output line_error,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input line_error,
                  output ready);
endinterface

FILE: src/urb_rsp_if.sv
interface urb_rsp_if;
  import urb_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_valid;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       flag_value;
  logic       tx_busy;

  modport source (output valid, output read_byte, output read_valid, output tx_byte,
                  output tx_valid, output flag_value, output tx_busy, input ready);
  modport sink   (input valid, input read_byte, input read_valid, input tx_byte,
                  input tx_valid, input flag_value, input tx_busy, output ready);
endinterface

FILE: src/urb_ram.sv
module urb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/urb_ctrl.sv
module urb_ctrl import urb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  urb_sts_t sts_i,
  output urb_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EXEC,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.latch = req_valid_i;
        if (req_valid_i) state_d = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the previous result beat has gone
        if (!sts_i.out_full) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

endmodule

FILE: src/urb_dp.sv
module urb_dp import urb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  urb_cmd_t   cmd_i,
  output urb_sts_t   sts_o,
  input  logic [2:0] req_type_i,
  input  logic [7:0] data_byte_i,
  input  logic       line_error_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output logic [7:0] read_byte_o,
  output logic       read_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic       flag_value_o,
  output logic       tx_busy_o
);

  req_type_e  type_q;
  logic [7:0] data_q;
  logic       lerr_q;

  ptr_t rx_wp_q, rx_rp_q, tx_wp_q, tx_rp_q;
  logic rx_ovr_q, tx_ovr_q, rx_acc_q;
  logic [7:0] last_q;
  logic rvalid_q, tvalid_q, flag_q;

  logic       out_valid_q;
  logic [7:0] read_byte_q, tx_byte_q;
  logic       read_valid_q, tx_valid_q, flag_value_q, tx_busy_q;

  ptr_t rx_wn, rx_rn, tx_wn, tx_rn;
  logic rx_empty, rx_full, tx_empty, tx_full;
  logic is_write, need_ins, push_en, tx_we, rx_we, rx_re, tx_re;
  logic [7:0] ins_char, push_char, rx_rdata, tx_rdata;

  assign rx_wn    = ptr_next(rx_wp_q);
  assign rx_rn    = ptr_next(rx_rp_q);
  assign tx_wn    = ptr_next(tx_wp_q);
  assign tx_rn    = ptr_next(tx_rp_q);
  assign rx_empty = (rx_wp_q == rx_rp_q);
  assign tx_empty = (tx_wp_q == tx_rp_q);
  assign rx_full  = (rx_wn == rx_rp_q);
  assign tx_full  = (tx_wn == tx_rp_q);

  // CR not followed by LF gets an LF; a bare LF gets a CR ahead of it
  assign is_write  = (type_q == REQ_CPU_WRITE);
  assign need_ins  = is_write && (((last_q == CHAR_CR) && (data_q != CHAR_LF)) ||
                                  ((data_q == CHAR_LF) && (last_q != CHAR_CR)));
  assign ins_char  = (last_q == CHAR_CR) ? CHAR_LF : CHAR_CR;
  assign push_en   = (cmd_i.insert && need_ins) || (cmd_i.exec && is_write);
  assign push_char = cmd_i.insert ? ins_char : data_q;
  assign tx_we     = push_en && !tx_full;

  assign rx_we = cmd_i.exec && (type_q == REQ_LINE_RX) && rx_acc_q && !rx_full;
  assign rx_re = cmd_i.exec && (type_q == REQ_CPU_READ) && !rx_empty;
  assign tx_re = cmd_i.exec && (type_q == REQ_LINE_TX) && !tx_empty;

  urb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wn),
    .wdata_i (data_q),
    .re_i    (rx_re),
    .raddr_i (rx_rn),
    .rdata_o (rx_rdata)
  );

  urb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wn),
    .wdata_i (push_char),
    .re_i    (tx_re),
    .raddr_i (tx_rn),
    .rdata_o (tx_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      type_q <= req_type_e'(req_type_i);
      data_q <= data_byte_i;
      lerr_q <= line_error_i;
    end
    if (cmd_i.exec) begin
      rvalid_q <= rx_re;
      tvalid_q <= tx_re;
      flag_q   <= ((type_q == REQ_CLR_RX_OVR) && rx_ovr_q) ||
                  ((type_q == REQ_CLR_TX_OVR) && tx_ovr_q);
    end
    if (cmd_i.load) begin
      read_byte_q  <= rvalid_q ? rx_rdata : 8'h00;
      read_valid_q <= rvalid_q;
      tx_byte_q    <= tvalid_q ? tx_rdata : 8'h00;
      tx_valid_q   <= tvalid_q;
      flag_value_q <= flag_q;
      tx_busy_q    <= !tx_empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wp_q     <= '0;
      rx_rp_q     <= '0;
      tx_wp_q     <= '0;
      tx_rp_q     <= '0;
      rx_ovr_q    <= 1'b0;
      tx_ovr_q    <= 1'b0;
      rx_acc_q    <= 1'b1;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push_en) begin
        if (tx_full) begin
          tx_ovr_q <= 1'b1;
        end else begin
          tx_wp_q <= tx_wn;
          last_q  <= push_char;
        end
      end
      if (cmd_i.exec) begin
        unique case (type_q)
          REQ_CPU_WRITE: ;
          REQ_CPU_READ: begin
            if (!rx_empty) begin
              rx_rp_q  <= rx_rn;
              rx_acc_q <= 1'b1;
            end
          end
          REQ_LINE_RX: begin
            if (rx_acc_q) begin
              if (rx_full) begin
                rx_ovr_q <= 1'b1;
                rx_acc_q <= 1'b0;
              end else begin
                rx_wp_q <= rx_wn;
              end
            end
            if (lerr_q) rx_ovr_q <= 1'b1;
          end
          REQ_LINE_TX: begin
            if (!tx_empty) tx_rp_q <= tx_rn;
          end
          REQ_CLR_RX_OVR: begin
            rx_ovr_q <= 1'b0;
            rx_acc_q <= 1'b1;
          end
          REQ_CLR_TX_OVR: tx_ovr_q <= 1'b0;
          REQ_FLUSH_RX: begin
            rx_wp_q  <= '0;
            rx_rp_q  <= '0;
            rx_acc_q <= 1'b1;
          end
          REQ_FLUSH_TX: begin
            tx_wp_q <= '0;
            tx_rp_q <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign rsp_valid_o    = out_valid_q;
  assign read_byte_o    = read_byte_q;
  assign read_valid_o   = read_valid_q;
  assign tx_byte_o      = tx_byte_q;
  assign tx_valid_o     = tx_valid_q;
  assign flag_value_o   = flag_value_q;
  assign tx_busy_o      = tx_busy_q;

endmodule

FILE: src/uart_ring_buffers_crlf.sv
// A result beat is offered once its request beat has passed the line-end insert
// slot, execute with ring memory access and result load; the load waits while
// the previous result is untaken. One request is handled at a time; a new
// request is taken while the previous result still waits in the output register.
// Reset (asynchronous, active low): rings empty, overrun flags clear, reception
// enabled, last tx-ring byte zero; ring memories need no clearing pass.
module uart_ring_buffers_crlf import urb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  urb_req_if.sink       req_i,
  urb_rsp_if.source     rsp_o
);

  urb_cmd_t cmd;
  urb_sts_t sts;

  urb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  urb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .data_byte_i  (req_i.data_byte),
    .line_error_i (req_i.line_error),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .read_byte_o  (rsp_o.read_byte),
    .read_valid_o (rsp_o.read_valid),
    .tx_byte_o    (rsp_o.tx_byte),
    .tx_valid_o   (rsp_o.tx_valid),
    .flag_value_o (rsp_o.flag_value),
    .tx_busy_o    (rsp_o.tx_busy)
  );

endmodule

FILE: src/urb_checker.sv
module urb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] read_byte_i,
  input logic       read_valid_i,
  input logic [7:0] tx_byte_i,
  input logic       tx_valid_i,
  input logic       flag_value_i
);

  // one request in flight: no beat taken right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken on back-to-back cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !read_valid_i) |-> (read_byte_i == 8'h00))
    else $error("read byte nonzero without a stored byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !tx_valid_i) |-> (tx_byte_i == 8'h00))
    else $error("tx byte nonzero without a byte for the line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ($countones({read_valid_i, tx_valid_i, flag_value_i}) <= 1))
    else $error("result beat answers more than one request kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable({read_byte_i, read_valid_i, tx_byte_i, tx_valid_i,
                               flag_value_i})))
    else $error("stalled result beat changed");

endmodule

bind uart_ring_buffers_crlf urb_checker u_urb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .read_byte_i  (rsp_o.read_byte),
  .read_valid_i (rsp_o.read_valid),
  .tx_byte_i    (rsp_o.tx_byte),
  .tx_valid_i   (rsp_o.tx_valid),
  .flag_value_i (rsp_o.flag_value)
);
